// File: rtl/plgs_pkg.sv
// Package with the shared constants and types of the path lookahead goal selector.
`timescale 1ns / 1ps

package plgs_pkg;

    localparam int IDX_W      = 10;
    localparam int PATH_DEPTH = 1 << IDX_W;
    localparam int LEN_W      = IDX_W + 1;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int THR_W      = 31;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int STEP_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [THR_W-1:0]  CUR_THR_RST   = THR_W'(1024);
    localparam logic [THR_W-1:0]  PRD_THR_RST   = THR_W'(2048);
    localparam logic [STEP_W-1:0] STEP_RST      = STEP_W'(1);
    localparam logic [IDX_W-1:0]  CUR_START_RST = '0;
    localparam logic [IDX_W-1:0]  PRD_START_RST = '0;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        mag_t;
    typedef logic [SQ_W-1:0]           sq_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUR_THR   = 3'd0,
        CFG_PRD_THR   = 3'd1,
        CFG_STEP      = 3'd2,
        CFG_CUR_START = 3'd3,
        CFG_PRD_START = 3'd4
    } cfg_reg_t;

endpackage

// File: rtl/path_lookahead_goal_selector_top.sv
// Path lookahead goal selector: waypoint memory, two goal cursors and the distance pipeline.
`timescale 1ns / 1ps

// Channel  | Handshake             | Beat contents
// ---------+-----------------------+------------------------------------------------------
// input    | in_valid / in_stall   | kind, path_first, coord_x, coord_y
// output   | out_valid / out_stall | current/predicted goal x, y and index
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// A waypoint beat is written to the waypoint memory, one per cycle while the input is not stalled.
// A pose tick holds the input through memory read, difference, square,
// then compare and advance, which also reads the goal waypoints; the next beat can
// enter as the result moves into the output register. A tick with no path is dropped
// without a result. Reset clears the path length and loads the cursors with their reset
// start values; the memory itself is not cleared. A stalled output holds further input.

module path_lookahead_goal_selector_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic                                path_first,
    input  logic signed [plgs_pkg::COORD_W-1:0] coord_x,
    input  logic signed [plgs_pkg::COORD_W-1:0] coord_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [plgs_pkg::COORD_W-1:0] current_goal_x,
    output logic signed [plgs_pkg::COORD_W-1:0] current_goal_y,
    output logic signed [plgs_pkg::COORD_W-1:0] predicted_goal_x,
    output logic signed [plgs_pkg::COORD_W-1:0] predicted_goal_y,
    output logic [plgs_pkg::IDX_W-1:0]          current_goal_index,
    output logic [plgs_pkg::IDX_W-1:0]          predicted_goal_index,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [plgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plgs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import plgs_pkg::*;

    function automatic mag_t abs_diff(coord_t a, coord_t b);
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] neg;
        d   = DIFF_W'(a) - DIFF_W'(b);
        neg = -d;
        return d[DIFF_W-1] ? neg[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

    function automatic idx_t clamp_idx(idx_t cur, idx_t last);
        return (cur > last) ? last : cur;
    endfunction

    function automatic idx_t advance_idx(idx_t cur, logic [STEP_W-1:0] step, idx_t last,
                                         logic near);
        len_t sum;
        sum = LEN_W'(cur) + LEN_W'(step);
        if (!near)
            return cur;
        return (sum > LEN_W'(last)) ? last : sum[IDX_W-1:0];
    endfunction

    // Configuration registers and the registered threshold squares.
    logic [THR_W-1:0]    cur_thr_reg;
    logic [THR_W-1:0]    prd_thr_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [THR_SQ_W-1:0] cur_thr_sq_reg;
    logic [THR_SQ_W-1:0] prd_thr_sq_reg;

    // Path and cursor state.
    len_t len_reg;
    len_t len_next;
    idx_t cur_cursor_reg;
    idx_t prd_cursor_reg;
    idx_t last_idx;

    // Waypoint memories and their registered read data.
    coord_t mem_x [PATH_DEPTH];
    coord_t mem_y [PATH_DEPTH];
    coord_t cur_wx_reg;
    coord_t cur_wy_reg;
    coord_t prd_wx_reg;
    coord_t prd_wy_reg;

    // Tick pipeline.
    logic   s1_v_reg;
    logic   s2_v_reg;
    logic   s3_v_reg;
    logic   s4_v_reg;
    coord_t pose_x_reg;
    coord_t pose_y_reg;
    idx_t   cur_at_reg;
    idx_t   prd_at_reg;
    mag_t   cur_ax_reg;
    mag_t   cur_ay_reg;
    mag_t   prd_ax_reg;
    mag_t   prd_ay_reg;
    sq_t    cur_sx_reg;
    sq_t    cur_sy_reg;
    sq_t    prd_sx_reg;
    sq_t    prd_sy_reg;

    logic   out_valid_reg;
    coord_t cur_gx_reg;
    coord_t cur_gy_reg;
    coord_t prd_gx_reg;
    coord_t prd_gy_reg;
    idx_t   cur_gi_reg;
    idx_t   prd_gi_reg;

    logic              in_acc;
    logic              wp_acc;
    logic              tick_acc;
    logic              wr_en;
    idx_t              wr_addr;
    logic              rd_en;
    idx_t              rd_addr_c;
    idx_t              rd_addr_p;
    logic [SQ_W:0]     cur_dist;
    logic [SQ_W:0]     prd_dist;
    logic              cur_near;
    logic              prd_near;
    idx_t              cur_new;
    idx_t              prd_new;
    logic              out_free;
    logic              cfg_acc;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;

    assign out_free = ~out_valid_reg | ~out_stall;
    assign in_stall = s1_v_reg | s2_v_reg | s3_v_reg | (s4_v_reg & ~out_free);
    assign in_acc   = in_valid & ~in_stall;
    assign wp_acc   = in_acc & ~kind;
    assign tick_acc = in_acc & kind & (len_reg != '0);

    assign last_idx = IDX_W'(len_reg - LEN_W'(1));

    // A new path restarts at entry zero; a full path ignores further points.
    always_comb
    begin
        len_next = len_reg;
        wr_en    = 1'b0;
        wr_addr  = len_reg[IDX_W-1:0];
        if (wp_acc)
        begin
            if (path_first)
            begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                len_next = LEN_W'(1);
            end
            else if (len_reg < LEN_W'(PATH_DEPTH))
            begin
                wr_en    = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    assign cur_dist = {1'b0, cur_sx_reg} + {1'b0, cur_sy_reg};
    assign prd_dist = {1'b0, prd_sx_reg} + {1'b0, prd_sy_reg};
    assign cur_near = cur_dist < (SQ_W + 1)'(cur_thr_sq_reg);
    assign prd_near = prd_dist < (SQ_W + 1)'(prd_thr_sq_reg);
    assign cur_new  = advance_idx(cur_at_reg, step_reg, last_idx, cur_near);
    assign prd_new  = advance_idx(prd_at_reg, step_reg, last_idx, prd_near);

    // The goal read in the last stage reuses the ports of the tick's first read.
    assign rd_en     = tick_acc | s3_v_reg;
    assign rd_addr_c = s3_v_reg ? cur_new : clamp_idx(cur_cursor_reg, last_idx);
    assign rd_addr_p = s3_v_reg ? prd_new : clamp_idx(prd_cursor_reg, last_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= coord_x;
            mem_y[wr_addr] <= coord_y;
        end
        if (rd_en)
        begin
            cur_wx_reg <= mem_x[rd_addr_c];
            cur_wy_reg <= mem_y[rd_addr_c];
            prd_wx_reg <= mem_x[rd_addr_p];
            prd_wy_reg <= mem_y[rd_addr_p];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_thr_reg    <= CUR_THR_RST;
            prd_thr_reg    <= PRD_THR_RST;
            step_reg       <= STEP_RST;
            cur_cursor_reg <= CUR_START_RST;
            prd_cursor_reg <= PRD_START_RST;
            len_reg        <= '0;
        end
        else
        begin
            len_reg <= len_next;
            if (s3_v_reg)
            begin
                cur_cursor_reg <= cur_new;
                prd_cursor_reg <= prd_new;
            end
            if (cfg_acc)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_CUR_THR:   cur_thr_reg    <= cfg_data[THR_W-1:0];
                    CFG_PRD_THR:   prd_thr_reg    <= cfg_data[THR_W-1:0];
                    CFG_STEP:      step_reg       <= cfg_data[STEP_W-1:0];
                    CFG_CUR_START: cur_cursor_reg <= cfg_data[IDX_W-1:0];
                    CFG_PRD_START: prd_cursor_reg <= cfg_data[IDX_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_thr_sq_reg <= THR_SQ_W'(cur_thr_reg) * THR_SQ_W'(cur_thr_reg);
        prd_thr_sq_reg <= THR_SQ_W'(prd_thr_reg) * THR_SQ_W'(prd_thr_reg);
        if (tick_acc)
        begin
            pose_x_reg <= coord_x;
            pose_y_reg <= coord_y;
            cur_at_reg <= clamp_idx(cur_cursor_reg, last_idx);
            prd_at_reg <= clamp_idx(prd_cursor_reg, last_idx);
        end
        if (s1_v_reg)
        begin
            cur_ax_reg <= abs_diff(cur_wx_reg, pose_x_reg);
            cur_ay_reg <= abs_diff(cur_wy_reg, pose_y_reg);
            prd_ax_reg <= abs_diff(prd_wx_reg, pose_x_reg);
            prd_ay_reg <= abs_diff(prd_wy_reg, pose_y_reg);
        end
        if (s2_v_reg)
        begin
            cur_sx_reg <= SQ_W'(cur_ax_reg) * SQ_W'(cur_ax_reg);
            cur_sy_reg <= SQ_W'(cur_ay_reg) * SQ_W'(cur_ay_reg);
            prd_sx_reg <= SQ_W'(prd_ax_reg) * SQ_W'(prd_ax_reg);
            prd_sy_reg <= SQ_W'(prd_ay_reg) * SQ_W'(prd_ay_reg);
        end
        if (s4_v_reg && out_free)
        begin
            cur_gx_reg <= cur_wx_reg;
            cur_gy_reg <= cur_wy_reg;
            prd_gx_reg <= prd_wx_reg;
            prd_gy_reg <= prd_wy_reg;
            cur_gi_reg <= cur_cursor_reg;
            prd_gi_reg <= prd_cursor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= tick_acc;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            if (s3_v_reg)
                s4_v_reg <= 1'b1;
            else if (out_free)
                s4_v_reg <= 1'b0;
            if (s4_v_reg && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid            = out_valid_reg;
    assign current_goal_x       = cur_gx_reg;
    assign current_goal_y       = cur_gy_reg;
    assign predicted_goal_x     = prd_gx_reg;
    assign predicted_goal_y     = prd_gy_reg;
    assign current_goal_index   = cur_gi_reg;
    assign predicted_goal_index = prd_gi_reg;

    // Only one tick is ever in flight.
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg}))
        else $error("more than one tick in the pipeline");

    // The goal read must not meet a waypoint write.
    a_no_write_on_goal_read: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> !wr_en)
        else $error("waypoint write during goal read");

    // After an update the cursors lie within the stored path.
    a_cursor_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        s4_v_reg |-> (cur_cursor_reg <= last_idx) && (prd_cursor_reg <= last_idx))
        else $error("cursor beyond last waypoint");

    // A result appears only for a tick that finished the pipeline.
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s4_v_reg))
        else $error("result without a finished tick");

endmodule

// File: verif/path_lookahead_goal_selector_checker.sv
// Checker that predicts the goal beats of the path lookahead goal selector and compares them.
`timescale 1ns / 1ps

module path_lookahead_goal_selector_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                kind,
    input  logic                                path_first,
    input  logic signed [plgs_pkg::COORD_W-1:0] coord_x,
    input  logic signed [plgs_pkg::COORD_W-1:0] coord_y,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [plgs_pkg::COORD_W-1:0] current_goal_x,
    input  logic signed [plgs_pkg::COORD_W-1:0] current_goal_y,
    input  logic signed [plgs_pkg::COORD_W-1:0] predicted_goal_x,
    input  logic signed [plgs_pkg::COORD_W-1:0] predicted_goal_y,
    input  logic [plgs_pkg::IDX_W-1:0]          current_goal_index,
    input  logic [plgs_pkg::IDX_W-1:0]          predicted_goal_index,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [plgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plgs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  errors,
    output int                                  outstanding
);

    import plgs_pkg::*;

    localparam int WIDE_W = SQ_W + 2;

    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        coord_t prd_x;
        coord_t prd_y;
        idx_t   cur_idx;
        idx_t   prd_idx;
    } goal_beat_t;

    goal_beat_t       pending_goals[$];
    coord_t           wp_x [PATH_DEPTH];
    coord_t           wp_y [PATH_DEPTH];
    len_t             path_len;
    logic             path_loaded;
    idx_t             cur_cursor;
    idx_t             prd_cursor;
    logic [THR_W-1:0] cur_thr;
    logic [THR_W-1:0] prd_thr;
    logic [STEP_W-1:0] adv_step;

    // Exact test of dx*dx + dy*dy < thr*thr; the widths leave room for the largest distance.
    function automatic logic in_reach(coord_t wx, coord_t wy, coord_t px, coord_t py,
                                      logic [THR_W-1:0] thr);
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
        logic [DIFF_W-1:0] ax;
        logic [DIFF_W-1:0] ay;
        logic [WIDE_W-1:0] dist2;
        logic [WIDE_W-1:0] lim2;
        dx = {wx[COORD_W-1], wx} - {px[COORD_W-1], px};
        dy = {wy[COORD_W-1], wy} - {py[COORD_W-1], py};
        ax = dx[DIFF_W-1] ? -dx : dx;
        ay = dy[DIFF_W-1] ? -dy : dy;
        dist2 = WIDE_W'(ax) * WIDE_W'(ax) + WIDE_W'(ay) * WIDE_W'(ay);
        lim2 = WIDE_W'(thr) * WIDE_W'(thr);
        return dist2 < lim2;
    endfunction

    function automatic idx_t advance_cursor(idx_t cur, coord_t px, coord_t py,
                                            logic [THR_W-1:0] thr);
        idx_t           last;
        logic [LEN_W:0] nxt;
        last = idx_t'(path_len - 1'b1);
        // A cursor left beyond a shorter path falls back to its last point first.
        if (cur > last)
            cur = last;
        if (in_reach(wp_x[cur], wp_y[cur], px, py, thr))
        begin
            nxt = (LEN_W+1)'(cur) + (LEN_W+1)'(adv_step);
            cur = (nxt > (LEN_W+1)'(last)) ? last : idx_t'(nxt);
        end
        return cur;
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [COORD_W-1:0] got,
                                 input logic [COORD_W-1:0] want);
        if (got !== want)
            report($sformatf("%s is %h, predicted %h", name, got, want));
    endtask

    task automatic check_goal();
        goal_beat_t want;
        if (pending_goals.size() == 0)
        begin
            report("goal beat arrived with none predicted");
        end
        else
        begin
            want = pending_goals.pop_front();
            compare_field("current_goal_x", current_goal_x, want.cur_x);
            compare_field("current_goal_y", current_goal_y, want.cur_y);
            compare_field("predicted_goal_x", predicted_goal_x, want.prd_x);
            compare_field("predicted_goal_y", predicted_goal_y, want.prd_y);
            compare_field("current_goal_index", COORD_W'(current_goal_index),
                          COORD_W'(want.cur_idx));
            compare_field("predicted_goal_index", COORD_W'(predicted_goal_index),
                          COORD_W'(want.prd_idx));
        end
    endtask

    task automatic apply_reg();
        case (cfg_reg_t'(cfg_index))
            CFG_CUR_THR:   cur_thr = cfg_data[THR_W-1:0];
            CFG_PRD_THR:   prd_thr = cfg_data[THR_W-1:0];
            CFG_STEP:      adv_step = cfg_data[STEP_W-1:0];
            CFG_CUR_START: cur_cursor = cfg_data[IDX_W-1:0];
            CFG_PRD_START: prd_cursor = cfg_data[IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic take_beat();
        goal_beat_t goal;
        if (!kind)
        begin
            if (path_first)
                path_len = '0;
            // Points past a full store are dropped.
            if (path_len < len_t'(PATH_DEPTH))
            begin
                wp_x[path_len[IDX_W-1:0]] = coord_x;
                wp_y[path_len[IDX_W-1:0]] = coord_y;
                path_len = path_len + 1'b1;
                path_loaded = 1'b1;
            end
        end
        else if (path_loaded && path_len != '0)
        begin
            cur_cursor = advance_cursor(cur_cursor, coord_x, coord_y, cur_thr);
            prd_cursor = advance_cursor(prd_cursor, coord_x, coord_y, prd_thr);
            goal.cur_x = wp_x[cur_cursor];
            goal.cur_y = wp_y[cur_cursor];
            goal.prd_x = wp_x[prd_cursor];
            goal.prd_y = wp_y[prd_cursor];
            goal.cur_idx = cur_cursor;
            goal.prd_idx = prd_cursor;
            pending_goals.push_back(goal);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_len = '0;
            path_loaded = 1'b0;
            cur_cursor = CUR_START_RST;
            prd_cursor = PRD_START_RST;
            cur_thr = CUR_THR_RST;
            prd_thr = PRD_THR_RST;
            adv_step = STEP_RST;
            pending_goals.delete();
            outstanding <= 0;
        end
        else
        begin
            // A result leaving at this edge always belongs to an earlier tick.
            if (out_valid && !out_stall)
                check_goal();
            if (cfg_valid && cfg_ready)
                apply_reg();
            if (in_valid && !in_stall)
                take_beat();
            outstanding <= pending_goals.size();
        end
    end

endmodule

// File: verif/testbench.sv
// Top of the goal selector testbench: clock, reset, stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module testbench;

    import plgs_pkg::*;

    localparam int     HALF_PERIOD   = 4;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     RANDOM_ITEMS  = 880;
    localparam coord_t COORD_MAX     = 32'sh7FFFFFFF;
    localparam coord_t COORD_MIN     = 32'sh80000000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic                  path_first;
    coord_t                coord_x;
    coord_t                coord_y;
    logic                  out_valid;
    logic                  out_stall;
    coord_t                current_goal_x;
    coord_t                current_goal_y;
    coord_t                predicted_goal_x;
    coord_t                predicted_goal_y;
    idx_t                  current_goal_index;
    idx_t                  predicted_goal_index;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int     errors;
    int     outstanding;
    int     cycles;
    logic   no_idle = 1'b0;
    coord_t path_x [PATH_DEPTH];
    coord_t path_y [PATH_DEPTH];
    int     path_count;
    int     walk;
    int     step_now;
    int     items_sent;
    coord_t lane_dx;
    coord_t lane_dy;

    path_lookahead_goal_selector_top u_top
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .kind                 (kind),
        .path_first           (path_first),
        .coord_x              (coord_x),
        .coord_y              (coord_y),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .current_goal_x       (current_goal_x),
        .current_goal_y       (current_goal_y),
        .predicted_goal_x     (predicted_goal_x),
        .predicted_goal_y     (predicted_goal_y),
        .current_goal_index   (current_goal_index),
        .predicted_goal_index (predicted_goal_index),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    path_lookahead_goal_selector_checker u_checker
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .kind                 (kind),
        .path_first           (path_first),
        .coord_x              (coord_x),
        .coord_y              (coord_y),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .current_goal_x       (current_goal_x),
        .current_goal_y       (current_goal_y),
        .predicted_goal_x     (predicted_goal_x),
        .predicted_goal_y     (predicted_goal_y),
        .current_goal_index   (current_goal_index),
        .predicted_goal_index (predicted_goal_index),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .errors               (errors),
        .outstanding          (outstanding)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_thr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 30)
            return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(256, 4096));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return '0;
        if (r < 80)
            return CFG_DATA_W'($urandom_range(0, PATH_DEPTH - 1));
        return CFG_DATA_W'(PATH_DEPTH - 1);
    endfunction

    // Output back pressure runs on its own, independent of out_valid.
    initial
    begin
        int g;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            g = pick_gap();
            if (g != 0)
            begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
        end
    end

    // Leaves in_valid high after the beat is taken, so the next beat can follow at once.
    task automatic send_beat(input logic k, input logic f, input coord_t x, input coord_t y);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        path_first <= f;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (!k)
        begin
            if (f)
                path_count = 0;
            if (path_count < PATH_DEPTH)
            begin
                path_x[path_count] = x;
                path_y[path_count] = y;
                path_count++;
            end
        end
    endtask

    task automatic tick(input coord_t x, input coord_t y);
        send_beat(1'b1, 1'b0, x, y);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Waypoint beats and ticks without a path give no result, so wait out the pipeline too.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_STEP)
            step_now = int'(data[STEP_W-1:0]);
        @(posedge clk);
    endtask

    task automatic random_config();
        int r;
        r = $urandom_range(0, 99);
        write_reg(CFG_CUR_THR, pick_thr());
        write_reg(CFG_PRD_THR, pick_thr());
        if (r < 8)
            write_reg(CFG_STEP, '0);
        else if (r < 16)
            write_reg(CFG_STEP, CFG_DATA_W'(PATH_DEPTH - 1));
        else if (r < 30)
            write_reg(CFG_STEP, CFG_DATA_W'($urandom_range(2, 20)));
        else
            write_reg(CFG_STEP, CFG_DATA_W'($urandom_range(1, 2)));
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_CUR_START, pick_start());
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_PRD_START, pick_start());
    endtask

    // Points follow a lane with some jitter; a few land anywhere in the coordinate range.
    task automatic add_point(input logic restart);
        coord_t x;
        coord_t y;
        if (restart || path_count == 0)
        begin
            x = $urandom;
            y = $urandom;
            lane_dx = $urandom_range(0, 3000) - 1500;
            lane_dy = $urandom_range(0, 3000) - 1500;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            x = $urandom;
            y = $urandom;
        end
        else
        begin
            x = path_x[path_count - 1] + lane_dx + $urandom_range(0, 400) - 200;
            y = path_y[path_count - 1] + lane_dy + $urandom_range(0, 400) - 200;
        end
        if (restart)
            walk = 0;
        send_beat(1'b0, restart, x, y);
    endtask

    // The pose walks along the stored path so that the goal cursors keep moving.
    task automatic walk_tick();
        int r;
        r = $urandom_range(0, 99);
        if (path_count == 0)
        begin
            tick($urandom, $urandom);
        end
        else
        begin
            if (r >= 93)
                walk = $urandom_range(0, path_count - 1);
            else if (r >= 85)
                walk += step_now;
            else if (r >= 45)
                walk++;
            if (walk > path_count - 1)
                walk = path_count - 1;
            tick(path_x[walk] + $urandom_range(0, 1400) - 700,
                 path_y[walk] + $urandom_range(0, 1400) - 700);
        end
    endtask

    task automatic run_phase(input int n);
        int stop_at;
        int r;
        int len;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 9)
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 120);
                add_point(1'b1);
                repeat (len - 1) add_point(1'b0);
            end
            else if (r < 14)
            begin
                repeat ($urandom_range(1, 4)) add_point(1'b0);
            end
            else if (r < 20)
            begin
                tick($urandom, $urandom);
            end
            else if (r < 22)
            begin
                drain();
            end
            else
            begin
                walk_tick();
            end
        end
    endtask

    initial
    begin
        int rand_goal;
        int phase;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= 1'b0;
        path_first <= 1'b0;
        coord_x <= '0;
        coord_y <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        path_count = 0;
        walk = 0;
        step_now = int'(STEP_RST);
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings: a tick before any path is dropped.
        tick('0, '0);
        send_beat(1'b0, 1'b1, '0, '0);
        send_beat(1'b0, 1'b0, 32'sd3000, '0);
        send_beat(1'b0, 1'b0, COORD_MAX, COORD_MIN);
        send_beat(1'b0, 1'b0, COORD_MIN, COORD_MAX);
        // Exactly at the current threshold, then one unit inside it.
        tick(32'sd1024, '0);
        tick(32'sd1023, '0);
        // Largest possible distances, then advances that clamp at the last point.
        tick(COORD_MIN, COORD_MAX);
        tick(COORD_MAX, COORD_MIN);
        tick(COORD_MIN, COORD_MAX);
        // A new path shorter than both cursors.
        send_beat(1'b0, 1'b1, -32'sd5, 32'sd7);
        tick(-32'sd5, 32'sd7);
        send_beat(1'b0, 1'b0, -32'sd5, 32'sd1030);
        tick(-32'sd5, 32'sd7);

        settle();
        write_reg(CFG_CUR_THR, '1);
        write_reg(CFG_PRD_THR, '1);
        write_reg(CFG_STEP, '0);
        tick(COORD_MAX, COORD_MAX);
        tick(-32'sd5, 32'sd1030);

        settle();
        write_reg(CFG_STEP, CFG_DATA_W'(PATH_DEPTH - 1));
        write_reg(CFG_CUR_THR, '0);
        write_reg(CFG_CUR_START, CFG_DATA_W'(PATH_DEPTH - 1));
        write_reg(CFG_PRD_START, CFG_DATA_W'(PATH_DEPTH - 1));
        tick(-32'sd5, 32'sd1030);

        rand_goal = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < rand_goal)
        begin
            settle();
            no_idle = (phase == 2);
            random_config();
            run_phase($urandom_range(60, 140));
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
